// ===== sv/dpd_pkg.sv =====
// ============================================================================
// dpd_pkg: shared types and widths for the dual PD drive correction
// Holds the request structs passed between the pipeline stages, the gain
// set and the register index codes.
// ============================================================================
package dpd_pkg;

    localparam int POS_W  = 32;
    localparam int BASE_W = 16;
    localparam int GAIN_W = 16;
    localparam int OFS_W  = 33;
    localparam int ERR_W  = 34;
    localparam int DER_W  = 35;
    localparam int PE_W   = ERR_W + GAIN_W;
    localparam int PD_W   = DER_W + GAIN_W;
    localparam int SUM_W  = PD_W + 1;
    localparam int MIX_W  = SUM_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_KP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_KD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_KP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_KD = 2'd3;

    typedef struct packed {
        logic                     first_frame;
        logic                     tare;
        logic signed [POS_W-1:0]  target_position;
        logic signed [POS_W-1:0]  target_rotation;
        logic signed [BASE_W-1:0] left_base;
        logic signed [BASE_W-1:0] right_base;
        logic signed [POS_W-1:0]  measured_position;
        logic signed [POS_W-1:0]  measured_rotation;
    } in_req_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err_pos;
        logic signed [DER_W-1:0]  der_pos;
        logic signed [ERR_W-1:0]  err_rot;
        logic signed [DER_W-1:0]  der_rot;
        logic signed [BASE_W-1:0] left_base;
        logic signed [BASE_W-1:0] right_base;
    } err_req_t;

    typedef struct packed {
        logic signed [PE_W-1:0]   pe_pos;
        logic signed [PD_W-1:0]   pd_pos;
        logic signed [PE_W-1:0]   pe_rot;
        logic signed [PD_W-1:0]   pd_rot;
        logic signed [BASE_W-1:0] left_base;
        logic signed [BASE_W-1:0] right_base;
    } prod_req_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] position_kp;
        logic signed [GAIN_W-1:0] position_kd;
        logic signed [GAIN_W-1:0] rotation_kp;
        logic signed [GAIN_W-1:0] rotation_kd;
    } gains_t;

endpackage

// ===== sv/dpd_err_stage.sv =====
// ============================================================================
// dpd_err_stage: error and derivative stage
// Keeps the offsets and previous errors, forms the saturated error and its
// difference for both loops and registers them.
// ============================================================================
module dpd_err_stage
    import dpd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  in_req_t  req,
    output err_req_t err_reg
);

    logic signed [OFS_W-1:0] pos_ofs_reg, pos_ofs_next;
    logic signed [OFS_W-1:0] rot_ofs_reg, rot_ofs_next;
    logic signed [ERR_W-1:0] pos_prev_reg, rot_prev_reg;
    logic signed [ERR_W-1:0] pos_prev_eff, rot_prev_eff;
    logic signed [DER_W-1:0] pos_raw, rot_raw;
    logic signed [ERR_W-1:0] pos_err, rot_err;
    err_req_t                err_next;

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [DER_W-1:0] x);
        logic signed [ERR_W-1:0] r;
        if (x[DER_W-1] != x[DER_W-2]) begin
            r = x[DER_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        end else begin
            r = x[ERR_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        // first frame drops the stored history; tare then re-latches offsets
        pos_ofs_next = req.first_frame ? '0 : pos_ofs_reg;
        rot_ofs_next = req.first_frame ? '0 : rot_ofs_reg;
        pos_prev_eff = req.first_frame ? '0 : pos_prev_reg;
        rot_prev_eff = req.first_frame ? '0 : rot_prev_reg;
        if (req.tare) begin
            pos_ofs_next = OFS_W'(req.measured_position) - OFS_W'(req.target_position);
            rot_ofs_next = OFS_W'(req.measured_rotation) - OFS_W'(req.target_rotation);
        end
        pos_raw = DER_W'(req.target_position) - DER_W'(req.measured_position)
                + DER_W'(pos_ofs_next);
        rot_raw = DER_W'(req.target_rotation) - DER_W'(req.measured_rotation)
                + DER_W'(rot_ofs_next);
        pos_err = sat_err(pos_raw);
        rot_err = sat_err(rot_raw);
        err_next.err_pos    = pos_err;
        err_next.der_pos    = DER_W'(pos_err) - DER_W'(pos_prev_eff);
        err_next.err_rot    = rot_err;
        err_next.der_rot    = DER_W'(rot_err) - DER_W'(rot_prev_eff);
        err_next.left_base  = req.left_base;
        err_next.right_base = req.right_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_ofs_reg  <= '0;
            rot_ofs_reg  <= '0;
            pos_prev_reg <= '0;
            rot_prev_reg <= '0;
        end else if (load) begin
            pos_ofs_reg  <= pos_ofs_next;
            rot_ofs_reg  <= rot_ofs_next;
            pos_prev_reg <= pos_err;
            rot_prev_reg <= rot_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            err_reg <= err_next;
        end
    end

endmodule

// ===== sv/dpd_gain_stage.sv =====
// ============================================================================
// dpd_gain_stage: gain multiply stage
// Multiplies each error and derivative by its gain and registers the four
// products.
// ============================================================================
module dpd_gain_stage
    import dpd_pkg::*;
(
    input  logic      aclk,
    input  logic      load,
    input  err_req_t  req,
    input  gains_t    gains,
    output prod_req_t prod_reg
);

    prod_req_t prod_next;

    always_comb begin
        prod_next.pe_pos     = PE_W'(req.err_pos) * PE_W'(gains.position_kp);
        prod_next.pd_pos     = PD_W'(req.der_pos) * PD_W'(gains.position_kd);
        prod_next.pe_rot     = PE_W'(req.err_rot) * PE_W'(gains.rotation_kp);
        prod_next.pd_rot     = PD_W'(req.der_rot) * PD_W'(gains.rotation_kd);
        prod_next.left_base  = req.left_base;
        prod_next.right_base = req.right_base;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== sv/dpd_mix_stage.sv =====
// ============================================================================
// dpd_mix_stage: correction mix and clamp stage
// Sums the products, scales them down, mixes them into both drive sides
// and clamps to 16-bit signed.
// ============================================================================
module dpd_mix_stage
    import dpd_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     load,
    input  prod_req_t                req,
    output logic signed [BASE_W-1:0] left_reg,
    output logic signed [BASE_W-1:0] right_reg,
    output logic                     sat_reg
);

    localparam logic signed [MIX_W-1:0] DRIVE_MAX = MIX_W'(32767);
    localparam logic signed [MIX_W-1:0] DRIVE_MIN = MIX_W'(-32768);

    logic signed [SUM_W-1:0]  pos_sum, rot_sum, pos_corr, rot_corr;
    logic signed [MIX_W-1:0]  left_mix, right_mix;
    logic signed [BASE_W-1:0] left_next, right_next;
    logic                     left_sat, right_sat;

    always_comb begin
        pos_sum  = SUM_W'(req.pe_pos) + SUM_W'(req.pd_pos);
        rot_sum  = SUM_W'(req.pe_rot) + SUM_W'(req.pd_rot);
        // arithmetic shift rounds toward minus infinity
        pos_corr = pos_sum >>> GAIN_FRACTION_BITS;
        rot_corr = rot_sum >>> GAIN_FRACTION_BITS;
        left_mix  = MIX_W'(req.left_base) + MIX_W'(pos_corr) + MIX_W'(rot_corr);
        right_mix = MIX_W'(req.right_base) + MIX_W'(pos_corr) - MIX_W'(rot_corr);

        left_sat  = 1'b1;
        right_sat = 1'b1;
        if (left_mix > DRIVE_MAX) begin
            left_next = BASE_W'(DRIVE_MAX);
        end else if (left_mix < DRIVE_MIN) begin
            left_next = BASE_W'(DRIVE_MIN);
        end else begin
            left_next = left_mix[BASE_W-1:0];
            left_sat  = 1'b0;
        end
        if (right_mix > DRIVE_MAX) begin
            right_next = BASE_W'(DRIVE_MAX);
        end else if (right_mix < DRIVE_MIN) begin
            right_next = BASE_W'(DRIVE_MIN);
        end else begin
            right_next = right_mix[BASE_W-1:0];
            right_sat  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg  <= left_next;
            right_reg <= right_next;
            sat_reg   <= left_sat | right_sat;
        end
    end

endmodule

// ===== sv/dual_pd_drive_correction.sv =====
// ============================================================================
// dual_pd_drive_correction: two PD loops correcting recorded drive frames
//
// Input channel (s_*): one request per frame with the recorded target
// position and heading, the left and right base drive values, the tare and
// first-frame flags and the current sensor readings.
// Result channel (m_*): one request per frame with the corrected left and
// right drive commands and a flag set when either was clamped.
// Configuration: cfg_wr_en writes cfg_wr_data into the gain at cfg_index
// (position kp, position kd, rotation kp, rotation kd, signed Q8.8). Write
// gains only while no frame is in flight.
// Throughput is one frame per cycle unless the receiver stalls. Frames pass
// input register, error stage (where offsets and previous errors update),
// gain multiply stage, then the mix/clamp result register driving m_valid.
// Reset clears the gains, the offsets, the previous errors and all valid
// bits. When the receiver stalls the result register holds; stages behind it
// keep filling until every stage is full, and only then s_ready drops.
// ============================================================================
module dual_pd_drive_correction
    import dpd_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [GAIN_W-1:0]           cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_first_frame,
    input  logic                        s_tare,
    input  logic signed [POS_W-1:0]     s_target_position,
    input  logic signed [POS_W-1:0]     s_target_rotation,
    input  logic signed [BASE_W-1:0]    s_left_base,
    input  logic signed [BASE_W-1:0]    s_right_base,
    input  logic signed [POS_W-1:0]     s_measured_position,
    input  logic signed [POS_W-1:0]     s_measured_rotation,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [BASE_W-1:0]    m_left_drive,
    output logic signed [BASE_W-1:0]    m_right_drive,
    output logic                        m_saturated
);

    gains_t    gains_reg;
    in_req_t   in_reg;
    err_req_t  err_req;
    prod_req_t prod_req;

    // stage valid bits: input, error, product, result
    logic v_in_reg, v_err_reg, v_prod_reg, v_out_reg;
    logic adv_in, adv_err, adv_prod, adv_out;
    logic ld_in, ld_err, ld_prod, ld_out;

    // Gain registers: plain write port, no read-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POSITION_KP: gains_reg.position_kp <= cfg_wr_data;
                REG_POSITION_KD: gains_reg.position_kd <= cfg_wr_data;
                REG_ROTATION_KP: gains_reg.rotation_kp <= cfg_wr_data;
                REG_ROTATION_KD: gains_reg.rotation_kd <= cfg_wr_data;
                default:         gains_reg <= gains_reg;
            endcase
        end
    end

    // A stage can take a request when it is empty or its own request moves on.
    always_comb begin
        adv_out  = !v_out_reg || m_ready;
        adv_prod = !v_prod_reg || adv_out;
        adv_err  = !v_err_reg || adv_prod;
        adv_in   = !v_in_reg || adv_err;
        ld_in    = s_valid && adv_in;
        ld_err   = v_in_reg && adv_err;
        ld_prod  = v_err_reg && adv_prod;
        ld_out   = v_prod_reg && adv_out;
    end

    assign s_ready = adv_in;
    assign m_valid = v_out_reg;

    // Advance valid bits; a stage empties when its request leaves unreplaced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg   <= 1'b0;
            v_err_reg  <= 1'b0;
            v_prod_reg <= 1'b0;
            v_out_reg  <= 1'b0;
        end else begin
            v_in_reg   <= ld_in   || (v_in_reg   && !adv_err);
            v_err_reg  <= ld_err  || (v_err_reg  && !adv_prod);
            v_prod_reg <= ld_prod || (v_prod_reg && !adv_out);
            v_out_reg  <= ld_out  || (v_out_reg  && !m_ready);
        end
    end

    // Capture the incoming frame.
    always_ff @(posedge aclk) begin
        if (ld_in) begin
            in_reg.first_frame       <= s_first_frame;
            in_reg.tare              <= s_tare;
            in_reg.target_position   <= s_target_position;
            in_reg.target_rotation   <= s_target_rotation;
            in_reg.left_base         <= s_left_base;
            in_reg.right_base        <= s_right_base;
            in_reg.measured_position <= s_measured_position;
            in_reg.measured_rotation <= s_measured_rotation;
        end
    end

    // Error stage owns the loop state; it updates only when a frame enters it.
    dpd_err_stage u_err (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (ld_err),
        .req     (in_reg),
        .err_reg (err_req)
    );

    dpd_gain_stage u_gain (
        .aclk     (aclk),
        .load     (ld_prod),
        .req      (err_req),
        .gains    (gains_reg),
        .prod_reg (prod_req)
    );

    // Result register: holds while the receiver stalls.
    dpd_mix_stage #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_mix (
        .aclk      (aclk),
        .load      (ld_out),
        .req       (prod_req),
        .left_reg  (m_left_drive),
        .right_reg (m_right_drive),
        .sat_reg   (m_saturated)
    );

endmodule

// ===== verif/tb_dual_pd_drive_correction.sv =====
// ============================================================================
// tb_dual_pd_drive_correction: self-checking bench for the dual PD corrector
// Drives frame requests under random valid/ready idling, predicts every
// corrected drive command with a bit-accurate scoreboard and compares each
// returned request field by field. Gains are reloaded between traffic phases,
// including the signed extremes, and the receiver holds off once long enough
// to back the pipeline up into the sender.
// ============================================================================
module tb_dual_pd_drive_correction;
    import dpd_pkg::*;

    localparam int GAIN_FRAC        = 8;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 230;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 4;      // settling margin after the last owed command

    localparam longint ERR_MAX   = (longint'(1) <<< (ERR_W - 1)) - 1;
    localparam longint ERR_MIN   = -ERR_MAX - 1;
    localparam longint DRIVE_MAX = 32767;
    localparam longint DRIVE_MIN = -32768;

    typedef struct {
        logic signed [BASE_W-1:0] left_drive;
        logic signed [BASE_W-1:0] right_drive;
        logic                     saturated;
    } drive_cmd_t;

    // Scoreboard: mirrors the gains, offsets and previous errors and keeps the
    // drive commands still owed by the block, oldest first.
    class drive_scoreboard;
        gains_t                  gains;
        logic signed [ERR_W-1:0] prev_pos_err;
        logic signed [ERR_W-1:0] prev_rot_err;
        logic signed [OFS_W-1:0] pos_ofs;
        logic signed [OFS_W-1:0] rot_ofs;
        drive_cmd_t              expected_drives[$];
        int                      mismatches;

        function new();
            gains        = '0;
            prev_pos_err = '0;
            prev_rot_err = '0;
            pos_ofs      = '0;
            rot_ofs      = '0;
            mismatches   = 0;
        endfunction

        function void write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
            case (idx)
                REG_POSITION_KP: gains.position_kp = value;
                REG_POSITION_KD: gains.position_kd = value;
                REG_ROTATION_KP: gains.rotation_kp = value;
                REG_ROTATION_KD: gains.rotation_kd = value;
                default: ;
            endcase
        endfunction

        function longint limit_error(longint x);
            if (x > ERR_MAX) return ERR_MAX;
            if (x < ERR_MIN) return ERR_MIN;
            return x;
        endfunction

        // Arithmetic shift: negative sums round toward minus infinity.
        function longint pd_correction(longint err, longint prev, longint kp, longint kd);
            return (err * kp + (err - prev) * kd) >>> GAIN_FRAC;
        endfunction

        function logic signed [BASE_W-1:0] clamp_drive(longint x, inout bit clipped);
            if (x > DRIVE_MAX) begin
                clipped = 1'b1;
                return BASE_W'(DRIVE_MAX);
            end
            if (x < DRIVE_MIN) begin
                clipped = 1'b1;
                return BASE_W'(DRIVE_MIN);
            end
            return BASE_W'(x);
        endfunction

        function void note_frame(in_req_t f);
            longint     tpos, trot, mpos, mrot;
            longint     pos_err, rot_err, pos_corr, rot_corr;
            drive_cmd_t cmd;
            bit         clipped;
            tpos    = longint'(f.target_position);
            trot    = longint'(f.target_rotation);
            mpos    = longint'(f.measured_position);
            mrot    = longint'(f.measured_rotation);
            clipped = 1'b0;
            // Clear comes first, so a first frame with tare still latches.
            if (f.first_frame) begin
                prev_pos_err = '0;
                prev_rot_err = '0;
                pos_ofs      = '0;
                rot_ofs      = '0;
            end
            if (f.tare) begin
                pos_ofs = OFS_W'(mpos - tpos);
                rot_ofs = OFS_W'(mrot - trot);
            end
            pos_err  = limit_error(tpos - (mpos - longint'(pos_ofs)));
            rot_err  = limit_error(trot - (mrot - longint'(rot_ofs)));
            pos_corr = pd_correction(pos_err, longint'(prev_pos_err),
                                     longint'(gains.position_kp),
                                     longint'(gains.position_kd));
            rot_corr = pd_correction(rot_err, longint'(prev_rot_err),
                                     longint'(gains.rotation_kp),
                                     longint'(gains.rotation_kd));
            prev_pos_err = ERR_W'(pos_err);
            prev_rot_err = ERR_W'(rot_err);
            cmd.left_drive  = clamp_drive(longint'(f.left_base) + pos_corr + rot_corr,
                                          clipped);
            cmd.right_drive = clamp_drive(longint'(f.right_base) + pos_corr - rot_corr,
                                          clipped);
            cmd.saturated   = clipped;
            expected_drives = {expected_drives, cmd};
        endfunction

        function void check_drive(drive_cmd_t got);
            drive_cmd_t want;
            if (expected_drives.size() == 0) begin
                $error("drive command with no frame pending: left %0d right %0d",
                       got.left_drive, got.right_drive);
                mismatches++;
                return;
            end
            want = expected_drives.pop_front();
            if (got.left_drive !== want.left_drive) begin
                $error("left_drive: expected %0d, got %0d", want.left_drive, got.left_drive);
                mismatches++;
            end
            if (got.right_drive !== want.right_drive) begin
                $error("right_drive: expected %0d, got %0d", want.right_drive,
                       got.right_drive);
                mismatches++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                mismatches++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [GAIN_W-1:0]        cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_first_frame;
    logic                     s_tare;
    logic signed [POS_W-1:0]  s_target_position;
    logic signed [POS_W-1:0]  s_target_rotation;
    logic signed [BASE_W-1:0] s_left_base;
    logic signed [BASE_W-1:0] s_right_base;
    logic signed [POS_W-1:0]  s_measured_position;
    logic signed [POS_W-1:0]  s_measured_rotation;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [BASE_W-1:0] m_left_drive;
    logic signed [BASE_W-1:0] m_right_drive;
    logic                     m_saturated;

    drive_scoreboard drives = new();

    // Idling switch shared by both sides; the last phase runs without gaps.
    bit idle_on      = 1'b1;
    // One-shot request for the receiver's long hold-off.
    bit hold_off_req = 1'b0;

    // Trajectory of the current well-formed frame sequence.
    int track_pos, track_rot, skew_pos, skew_rot;

    dual_pd_drive_correction #(
        .GAIN_FRACTION_BITS(GAIN_FRAC)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_frame      (s_first_frame),
        .s_tare             (s_tare),
        .s_target_position  (s_target_position),
        .s_target_rotation  (s_target_rotation),
        .s_left_base        (s_left_base),
        .s_right_base       (s_right_base),
        .s_measured_position(s_measured_position),
        .s_measured_rotation(s_measured_rotation),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_left_drive       (m_left_drive),
        .m_right_drive      (m_right_drive),
        .m_saturated        (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run, even with every request
    // waiting out the longest gap and stall on both sides.
    initial begin
        #5_000_000;
        $display("FAIL dual_pd_drive_correction");
        $finish;
    end

    function automatic in_req_t make_frame(
        input bit first, input bit tare,
        input logic signed [POS_W-1:0] tpos, input logic signed [POS_W-1:0] trot,
        input logic signed [BASE_W-1:0] lbase, input logic signed [BASE_W-1:0] rbase,
        input logic signed [POS_W-1:0] mpos, input logic signed [POS_W-1:0] mrot);
        in_req_t f;
        f.first_frame       = first;
        f.tare              = tare;
        f.target_position   = tpos;
        f.target_rotation   = trot;
        f.left_base         = lbase;
        f.right_base        = rbase;
        f.measured_position = mpos;
        f.measured_rotation = mrot;
        return f;
    endfunction

    // Small gains so the drives stay in range, with zero, the signed
    // extremes and fully random values mixed in about twice as often.
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            5:       return GAIN_W'($urandom);
            default: return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic signed [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return BASE_W'($urandom);
            default: return BASE_W'(int'($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    function automatic void start_track();
        track_pos = $urandom;
        track_rot = $urandom;
        skew_pos  = int'($urandom_range(0, 4000)) - 2000;
        skew_rot  = int'($urandom_range(0, 4000)) - 2000;
    endfunction

    // Well-formed frame: targets creep along, sensors follow with a skew that
    // tare cancels and a little noise on top.
    function automatic in_req_t track_frame(input bit first);
        in_req_t f;
        track_pos += int'($urandom_range(0, 400)) - 200;
        track_rot += int'($urandom_range(0, 400)) - 200;
        if ($urandom_range(0, 15) == 0) skew_pos += int'($urandom_range(0, 2000)) - 1000;
        if ($urandom_range(0, 15) == 0) skew_rot += int'($urandom_range(0, 2000)) - 1000;
        f.first_frame       = first;
        f.tare              = (first && $urandom_range(0, 1)) || ($urandom_range(0, 11) == 0);
        f.target_position   = track_pos;
        f.target_rotation   = track_rot;
        f.left_base         = pick_base();
        f.right_base        = pick_base();
        f.measured_position = track_pos + skew_pos + int'($urandom_range(0, 600)) - 300;
        f.measured_rotation = track_rot + skew_rot + int'($urandom_range(0, 600)) - 300;
        return f;
    endfunction

    function automatic in_req_t noise_frame();
        in_req_t f;
        f.first_frame       = ($urandom_range(0, 3) == 0);
        f.tare              = ($urandom_range(0, 3) == 0);
        f.target_position   = $urandom;
        f.target_rotation   = $urandom;
        f.left_base         = BASE_W'($urandom);
        f.right_base        = BASE_W'($urandom);
        f.measured_position = $urandom;
        f.measured_rotation = $urandom;
        return f;
    endfunction

    // Offer one frame request; hold valid and payload until the block takes it.
    // Entered and left at a rising edge, so valid only drops when a gap is due.
    task automatic send_frame(input in_req_t f);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_first_frame       <= f.first_frame;
        s_tare              <= f.tare;
        s_target_position   <= f.target_position;
        s_target_rotation   <= f.target_rotation;
        s_left_base         <= f.left_base;
        s_right_base        <= f.right_base;
        s_measured_position <= f.measured_position;
        s_measured_rotation <= f.measured_rotation;
        do @(posedge aclk); while (s_ready !== 1'b1);
        drives.note_frame(f);
    endtask

    // Drop valid, wait for every owed command, then let the pipeline settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (drives.expected_drives.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all four gains back to back; only called while the block is idle.
    task automatic load_gains(input logic [GAIN_W-1:0] pos_kp, input logic [GAIN_W-1:0] pos_kd,
                              input logic [GAIN_W-1:0] rot_kp, input logic [GAIN_W-1:0] rot_kd);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [GAIN_W-1:0]    val [4];
        idx = '{REG_POSITION_KP, REG_POSITION_KD, REG_ROTATION_KP, REG_ROTATION_KD};
        val = '{pos_kp, pos_kd, rot_kp, rot_kd};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx[i];
            cfg_wr_data <= val[i];
            @(posedge aclk);
            drives.write_gain(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: sample at the edge, then pick ready for the next cycle.
    // Stalls come in short random bursts, plus one long hold-off on request.
    initial begin : drive_sink
        drive_cmd_t got;
        int         stall_left;
        stall_left = 0;
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                got.left_drive  = m_left_drive;
                got.right_drive = m_right_drive;
                got.saturated   = m_saturated;
                drives.check_drive(got);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : frame_source
        int sent;
        int seq_len;

        // Hold every input at a known value through reset.
        aresetn             <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= REG_POSITION_KP;
        cfg_wr_data         <= '0;
        s_valid             <= 1'b0;
        s_first_frame       <= 1'b0;
        s_tare              <= 1'b0;
        s_target_position   <= '0;
        s_target_rotation   <= '0;
        s_left_base         <= '0;
        s_right_base        <= '0;
        s_measured_position <= '0;
        s_measured_rotation <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Gains still at reset zero: drives pass the base values straight through.
        send_frame(make_frame(1, 0, 1000, -500, 1234, -4321, 900, -400));
        send_frame(make_frame(0, 0, 32'sh7FFFFFFF, 32'sh80000000, 16'sh7FFF, 16'sh8000,
                              32'sh80000000, 32'sh7FFFFFFF));
        wait_drained();

        // Moderate gains: plain errors, floor rounding of a negative sum, tare.
        load_gains(16'd256, 16'd128, -16'sd256, 16'd64);
        send_frame(make_frame(1, 0, 100, 0, 0, 0, 90, 10));
        send_frame(make_frame(0, 0, 100, 0, 0, 0, 101, 0));
        send_frame(make_frame(0, 1, 5000, 7000, -100, 100, 4000, 9000));
        send_frame(make_frame(0, 0, 5010, 7000, -100, 100, 4003, 9001));
        // Tare together with first frame: clear, then latch.
        send_frame(make_frame(1, 1, 0, 0, 16'sh7FFF, 16'sh8000, 55, -77));
        // Push left past the top, then right past the bottom.
        send_frame(make_frame(0, 0, 0, 0, 16'sh7FFF, 16'sh8000, -945, -77));
        send_frame(make_frame(0, 0, 0, 0, 16'sh7FFF, 16'sh8000, 1055, -77));
        // Widest errors: full-scale inputs, then offsets latched at full scale.
        send_frame(make_frame(1, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0,
                              32'sh80000000, 32'sh7FFFFFFF));
        send_frame(make_frame(1, 1, 32'sh80000000, 32'sh7FFFFFFF, 0, 0,
                              32'sh7FFFFFFF, 32'sh80000000));
        send_frame(make_frame(0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0,
                              32'sh80000000, 32'sh7FFFFFFF));
        wait_drained();

        // Extreme gains of both signs over the same corner frames.
        load_gains(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_frame(make_frame(0, 0, -1, -1, -1, -1, 0, 0));
        send_frame(make_frame(0, 0, 0, 0, 0, 0, -1, -1));
        send_frame(make_frame(1, 0, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(1, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0,
                              32'sh80000000, 32'sh7FFFFFFF));
        send_frame(make_frame(1, 1, 32'sh80000000, 32'sh7FFFFFFF, 0, 0,
                              32'sh7FFFFFFF, 32'sh80000000));
        send_frame(make_frame(0, 0, 32'sh7FFFFFFF, 32'sh80000000, 16'sh8000, 16'sh7FFF,
                              32'sh80000000, 32'sh7FFFFFFF));

        // Random phases: mostly tracking sequences opened by a first frame,
        // with fully random requests mixed in as noise.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       load_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                1:       load_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
                default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
            endcase
            // Back the pipeline up until it stalls the sender.
            if (ph == 2) hold_off_req = 1'b1;
            if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
            sent = 0;
            while (sent < FRAMES_PER_PHASE) begin
                seq_len = $urandom_range(5, 40);
                start_track();
                for (int k = 0; k < seq_len && sent < FRAMES_PER_PHASE; k++) begin
                    if ($urandom_range(0, 7) == 0) send_frame(noise_frame());
                    else send_frame(track_frame(k == 0));
                    sent++;
                end
            end
        end

        wait_drained();
        if (drives.mismatches == 0 && drives.expected_drives.size() == 0) begin
            $display("PASS dual_pd_drive_correction");
        end else begin
            $display("FAIL dual_pd_drive_correction");
        end
        $finish;
    end

endmodule
